[rtl/core/epdpc_pkg.sv]
package epdpc_pkg;

    localparam int CountW = 32;
    localparam int AngleW = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_INTERVAL = 3'd0;
    localparam logic [2:0] CFG_DPC      = 3'd1;
    localparam logic [2:0] CFG_ALPHA    = 3'd2;
    localparam logic [2:0] CFG_GAIN_P   = 3'd3;
    localparam logic [2:0] CFG_GAIN_D   = 3'd4;
    localparam logic [2:0] CFG_MAX_PWM  = 3'd5;

    localparam logic [15:0] RST_INTERVAL = 16'd3000;
    localparam logic [23:0] RST_DPC      = 24'd451270;
    localparam logic [16:0] RST_ALPHA    = 17'd3277;
    localparam logic [23:0] RST_GAIN_P   = 24'd179200;
    localparam logic [23:0] RST_GAIN_D   = 24'd12800;
    localparam logic [7:0]  RST_MAX_PWM  = 8'd200;
    localparam logic [16:0] ALPHA_ONE    = 17'd65536;

    // microseconds per second, as a multiplier operand
    localparam logic signed [24:0] US_PER_S = 25'sd1000000;

    typedef enum logic [2:0] {
        MUL_ANG = 3'd0,
        MUL_P   = 3'd1,
        MUL_D   = 3'd2,
        MUL_VEL = 3'd3,
        MUL_LO  = 3'd4,
        MUL_HI  = 3'd5,
        MUL_FLT = 3'd6
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     dc_ld;
        mul_sel_t mul_sel;
        logic     angle_ld;
        logic     err_ld;
        logic     dif_ld;
        logic     acc_ld;
        logic     acc_add;
        logic     drive_ld;
        logic     mag_ld;
        logic     num_ld;
        logic     num_add;
        logic     div_init;
        logic     div_step;
        logic     raw_ld;
        logic     fdiff_ld;
        logic     filt_ld;
        logic     out_ld;
    } cmd_t;

    typedef struct packed {
        logic vel_run;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/encoder_pd_position_controller_core.sv]
// PD position controller with a filtered velocity estimate.
// Input channel s_*: one request per control tick carrying the encoder count,
// a microsecond timestamp and the target angle (Q16.16).
// Output channel m_*: one result per request with the reverse/forward drive
// magnitudes, the measured angle, the filtered velocity and, on tuser, a flag
// that says whether this tick refreshed the velocity estimate.
// Config channel cfg_*: register index and data; write only while idle.
// A request that refreshes the velocity passes through more states than one
// that does not; s_tready returns together with m_tvalid. The 31-step
// restoring divider for the raw velocity takes the longest; everything else
// shares one 34x25 multiplier.
// One request is worked on at a time; s_tready rises again once the result
// has moved into the output register, so the next request can enter while
// that result waits on m_tready.
// A stalled receiver holds the result in the output register; a finished
// request then waits in its last step until the register frees up.
// Reset (aresetn low, synchronous) loads the default registers and clears
// the stored count, time, filtered velocity and previous error.
module encoder_pd_position_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] encoder_count, [63:32] time_us, [95:64] target_deg
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] drive_reverse, [15:8] drive_forward, [47:16] angle_deg,
    // [79:48] velocity_deg_s
    output logic [79:0] m_tdata,
    // [0] velocity_updated
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] interval_reg;
    logic [23:0] dpc_reg;
    logic [16:0] alpha_reg;
    logic [23:0] gain_p_reg;
    logic [23:0] gain_d_reg;
    logic [7:0]  max_pwm_reg;

    epdpc_pkg::cmd_t    cmd;
    epdpc_pkg::status_t status;

    logic [7:0]         drive_reverse, drive_forward;
    logic signed [31:0] angle_deg, velocity_deg_s;
    logic               velocity_updated;

    assign cfg_ready = 1'b1;

    // register file; alpha above one is clamped to one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= epdpc_pkg::RST_INTERVAL;
            dpc_reg      <= epdpc_pkg::RST_DPC;
            alpha_reg    <= epdpc_pkg::RST_ALPHA;
            gain_p_reg   <= epdpc_pkg::RST_GAIN_P;
            gain_d_reg   <= epdpc_pkg::RST_GAIN_D;
            max_pwm_reg  <= epdpc_pkg::RST_MAX_PWM;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                epdpc_pkg::CFG_INTERVAL: interval_reg <= cfg_data[15:0];
                epdpc_pkg::CFG_DPC:      dpc_reg      <= cfg_data[23:0];
                epdpc_pkg::CFG_ALPHA: begin
                    alpha_reg <= (cfg_data[16:0] > epdpc_pkg::ALPHA_ONE)
                        ? epdpc_pkg::ALPHA_ONE : cfg_data[16:0];
                end
                epdpc_pkg::CFG_GAIN_P:   gain_p_reg   <= cfg_data[23:0];
                epdpc_pkg::CFG_GAIN_D:   gain_d_reg   <= cfg_data[23:0];
                epdpc_pkg::CFG_MAX_PWM:  max_pwm_reg  <= cfg_data[7:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    epdpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epdpc_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .in_count             (s_tdata[31:0]),
        .in_time              (s_tdata[63:32]),
        .in_target            (s_tdata[95:64]),
        .cfg_interval         (interval_reg),
        .cfg_dpc              (dpc_reg),
        .cfg_alpha            (alpha_reg),
        .cfg_gain_p           (gain_p_reg),
        .cfg_gain_d           (gain_d_reg),
        .cfg_max_pwm          (max_pwm_reg),
        .out_drive_reverse    (drive_reverse),
        .out_drive_forward    (drive_forward),
        .out_angle_deg        (angle_deg),
        .out_velocity_deg_s   (velocity_deg_s),
        .out_velocity_updated (velocity_updated)
    );

    assign m_tdata = {velocity_deg_s, angle_deg, drive_forward, drive_reverse};
    assign m_tuser = velocity_updated;

    // the block is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in flight");

    // at most one bridge input is driven
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == 8'd0) || (m_tdata[15:8] == 8'd0))
        else $error("both drive magnitudes nonzero");

    // drive magnitudes respect the limit
    a_drive_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= max_pwm_reg) && (m_tdata[15:8] <= max_pwm_reg))
        else $error("drive magnitude above max_pwm");

endmodule

[rtl/core/epdpc_ctrl.sv]
module epdpc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  epdpc_pkg::status_t  status,
    output epdpc_pkg::cmd_t     cmd
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'd1 << 0,
        S_ANG   = 21'd1 << 1,
        S_ANGW  = 21'd1 << 2,
        S_ERR   = 21'd1 << 3,
        S_PMUL  = 21'd1 << 4,
        S_DMUL  = 21'd1 << 5,
        S_PACC  = 21'd1 << 6,
        S_DRV   = 21'd1 << 7,
        S_VMUL  = 21'd1 << 8,
        S_VMAG  = 21'd1 << 9,
        S_VLO   = 21'd1 << 10,
        S_VHI   = 21'd1 << 11,
        S_VSUM  = 21'd1 << 12,
        S_DINIT = 21'd1 << 13,
        S_DIV   = 21'd1 << 14,
        S_RAW   = 21'd1 << 15,
        S_FDIF  = 21'd1 << 16,
        S_FMUL  = 21'd1 << 17,
        S_FADD  = 21'd1 << 18,
        S_DONE  = 21'd1 << 19,
        S_SPARE = 21'd1 << 20
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        cmd.mul_sel   = epdpc_pkg::MUL_ANG;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_ANG;
                end
            end
            S_ANG: begin
                cmd.dc_ld   = 1'b1;
                cmd.mul_sel = epdpc_pkg::MUL_ANG;
                state_next  = S_ANGW;
            end
            S_ANGW: begin
                cmd.angle_ld = 1'b1;
                state_next   = S_ERR;
            end
            S_ERR: begin
                cmd.err_ld = 1'b1;
                state_next = S_PMUL;
            end
            S_PMUL: begin
                cmd.mul_sel = epdpc_pkg::MUL_P;
                cmd.dif_ld  = 1'b1;
                state_next  = S_DMUL;
            end
            S_DMUL: begin
                cmd.mul_sel = epdpc_pkg::MUL_D;
                cmd.acc_ld  = 1'b1;
                state_next  = S_PACC;
            end
            S_PACC: begin
                cmd.acc_add = 1'b1;
                state_next  = S_DRV;
            end
            S_DRV: begin
                cmd.drive_ld = 1'b1;
                state_next   = status.vel_run ? S_VMUL : S_DONE;
            end
            S_VMUL: begin
                cmd.mul_sel = epdpc_pkg::MUL_VEL;
                state_next  = S_VMAG;
            end
            S_VMAG: begin
                cmd.mag_ld = 1'b1;
                state_next = S_VLO;
            end
            S_VLO: begin
                cmd.mul_sel = epdpc_pkg::MUL_LO;
                state_next  = S_VHI;
            end
            S_VHI: begin
                cmd.mul_sel = epdpc_pkg::MUL_HI;
                cmd.num_ld  = 1'b1;
                state_next  = S_VSUM;
            end
            S_VSUM: begin
                cmd.num_add = 1'b1;
                state_next  = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                div_cnt_next = 5'd30;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == 5'd0) begin
                    state_next = S_RAW;
                end else begin
                    div_cnt_next = div_cnt_reg - 5'd1;
                end
            end
            S_RAW: begin
                cmd.raw_ld = 1'b1;
                state_next = S_FDIF;
            end
            S_FDIF: begin
                cmd.fdiff_ld = 1'b1;
                state_next   = S_FMUL;
            end
            S_FMUL: begin
                cmd.mul_sel = epdpc_pkg::MUL_FLT;
                state_next  = S_FADD;
            end
            S_FADD: begin
                cmd.filt_ld = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_ld    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/core/epdpc_dp.sv]
module epdpc_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  epdpc_pkg::cmd_t     cmd,
    output epdpc_pkg::status_t  status,
    input  logic signed [31:0]  in_count,
    input  logic [31:0]         in_time,
    input  logic signed [31:0]  in_target,
    input  logic [15:0]         cfg_interval,
    input  logic [23:0]         cfg_dpc,
    input  logic [16:0]         cfg_alpha,
    input  logic [23:0]         cfg_gain_p,
    input  logic [23:0]         cfg_gain_d,
    input  logic [7:0]          cfg_max_pwm,
    output logic [7:0]          out_drive_reverse,
    output logic [7:0]          out_drive_forward,
    output logic signed [31:0]  out_angle_deg,
    output logic signed [31:0]  out_velocity_deg_s,
    output logic                out_velocity_updated
);

    // persistent controller state
    logic signed [31:0] last_count_reg;
    logic [31:0]        last_time_reg;
    logic signed [31:0] filt_reg;
    logic signed [31:0] prev_err_reg;

    // per-request working registers
    logic signed [31:0] count_reg, target_reg;
    logic [31:0]        time_reg, elapsed_reg;
    logic               upd_reg, vel_run_reg;
    logic               dc_neg_reg;
    logic [32:0]        dc_mag_reg;
    logic signed [31:0] angle_reg, err_reg;
    logic signed [32:0] dif_reg;
    logic signed [59:0] acc_reg;
    logic [7:0]         rev_reg, fwd_reg;
    logic [55:0]        mag_reg;
    logic [75:0]        num_reg;
    logic [75:0]        dsh_reg;
    logic [30:0]        q_reg;
    logic               ovf_reg;
    logic signed [31:0] raw_reg;
    logic signed [32:0] fdiff_reg;
    logic signed [58:0] prod_reg;

    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic [31:0]        elapsed;
    logic signed [32:0] dc;
    logic signed [32:0] err_wide;
    logic [59:0]        acc_mag;
    logic [35:0]        acc_int;
    logic [7:0]         drive_clip;
    logic [39:0]        den;
    logic [75:0]        div_lim;
    logic signed [42:0] flt_step;

    assign status.vel_run = vel_run_reg;
    assign elapsed   = in_time - last_time_reg;
    assign dc        = {count_reg[31], count_reg} - {last_count_reg[31], last_count_reg};
    assign err_wide  = {target_reg[31], target_reg} - {angle_reg[31], angle_reg};
    assign acc_mag   = acc_reg[59] ? (60'd0 - acc_reg) : acc_reg;
    assign acc_int   = acc_mag[59:24];
    assign drive_clip = (acc_int > {28'd0, cfg_max_pwm}) ? cfg_max_pwm : acc_int[7:0];
    assign den       = {elapsed_reg, 8'd0};
    assign div_lim   = {5'd0, den, 31'd0};
    assign flt_step  = prod_reg[58:16];

    always_comb begin
        case (cmd.mul_sel)
            epdpc_pkg::MUL_ANG: begin
                mul_a = {{2{count_reg[31]}}, count_reg};
                mul_b = {1'b0, cfg_dpc};
            end
            epdpc_pkg::MUL_P: begin
                mul_a = {{2{err_reg[31]}}, err_reg};
                mul_b = {1'b0, cfg_gain_p};
            end
            epdpc_pkg::MUL_D: begin
                mul_a = {dif_reg[32], dif_reg};
                mul_b = {1'b0, cfg_gain_d};
            end
            epdpc_pkg::MUL_VEL: begin
                mul_a = {1'b0, dc_mag_reg};
                mul_b = {1'b0, cfg_dpc};
            end
            epdpc_pkg::MUL_LO: begin
                mul_a = {2'd0, mag_reg[31:0]};
                mul_b = epdpc_pkg::US_PER_S;
            end
            epdpc_pkg::MUL_HI: begin
                mul_a = {10'd0, mag_reg[55:32]};
                mul_b = epdpc_pkg::US_PER_S;
            end
            default: begin
                mul_a = {fdiff_reg[32], fdiff_reg};
                mul_b = {8'd0, cfg_alpha};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
            last_time_reg  <= '0;
            filt_reg       <= '0;
            prev_err_reg   <= '0;
            vel_run_reg    <= 1'b0;
            upd_reg        <= 1'b0;
        end else begin
            if (cmd.capture) begin
                upd_reg     <= (elapsed >= {16'd0, cfg_interval});
                vel_run_reg <= (elapsed >= {16'd0, cfg_interval}) && (elapsed != 32'd0);
            end
            if (cmd.dc_ld && upd_reg) begin
                last_count_reg <= count_reg;
                last_time_reg  <= time_reg;
            end
            if (cmd.drive_ld) begin
                prev_err_reg <= err_reg;
            end
            if (cmd.filt_ld) begin
                filt_reg <= epdpc_pkg::sat32({{32{filt_reg[31]}}, filt_reg}
                    + {{21{flt_step[42]}}, flt_step});
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture) begin
            count_reg   <= in_count;
            time_reg    <= in_time;
            target_reg  <= in_target;
            elapsed_reg <= elapsed;
        end
        if (cmd.dc_ld) begin
            dc_neg_reg <= dc[32];
            dc_mag_reg <= dc[32] ? (33'd0 - dc) : dc;
        end
        if (cmd.angle_ld) begin
            angle_reg <= epdpc_pkg::sat32({{13{prod_reg[58]}}, prod_reg[58:8]});
        end
        if (cmd.err_ld) begin
            err_reg <= epdpc_pkg::sat32({{31{err_wide[32]}}, err_wide});
        end
        if (cmd.dif_ld) begin
            dif_reg <= {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
        end
        if (cmd.acc_ld) begin
            acc_reg <= {prod_reg[58], prod_reg};
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + {prod_reg[58], prod_reg};
        end
        if (cmd.drive_ld) begin
            rev_reg <= acc_reg[59] ? drive_clip : 8'd0;
            fwd_reg <= acc_reg[59] ? 8'd0 : drive_clip;
        end
        if (cmd.mag_ld) begin
            mag_reg <= prod_reg[55:0];
        end
        if (cmd.num_ld) begin
            num_reg <= {17'd0, prod_reg};
        end else if (cmd.num_add) begin
            num_reg <= num_reg + {prod_reg[43:0], 32'd0};
        end else if (cmd.div_step) begin
            // restoring division, one quotient bit per cycle
            if (num_reg >= dsh_reg) begin
                num_reg <= num_reg - dsh_reg;
            end
        end
        if (cmd.div_init) begin
            ovf_reg <= (num_reg >= div_lim);
            dsh_reg <= {6'd0, den, 30'd0};
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            q_reg   <= {q_reg[29:0], (num_reg >= dsh_reg)};
            dsh_reg <= {1'b0, dsh_reg[75:1]};
        end
        if (cmd.raw_ld) begin
            if (dc_neg_reg) begin
                raw_reg <= ovf_reg ? 32'sh8000_0000 : (32'sd0 - $signed({1'b0, q_reg}));
            end else begin
                raw_reg <= ovf_reg ? 32'sh7FFF_FFFF : $signed({1'b0, q_reg});
            end
        end
        if (cmd.fdiff_ld) begin
            fdiff_reg <= {raw_reg[31], raw_reg} - {filt_reg[31], filt_reg};
        end
        if (cmd.out_ld) begin
            out_drive_reverse    <= rev_reg;
            out_drive_forward    <= fwd_reg;
            out_angle_deg        <= angle_reg;
            out_velocity_deg_s   <= filt_reg;
            out_velocity_updated <= vel_run_reg;
        end
    end

endmodule
